// ===== sv/olr_pkg.sv =====
// Shared codes for the octant line rasterizer.
// No dependencies; the files that use it refer to it by scoped names.
package olr_pkg;

  // Request kinds carried on the input channel (only this bit is decoded).
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  // Octants, counter-clockwise from +x.
  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_t;

endpackage

// ===== sv/olr_in_if.sv =====
// Input channel of the line rasterizer: valid/ready plus the request fields.
// Depends on nothing; the top level takes the sink modport.
interface olr_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end,
    input  ready
  );

  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end,
    output ready
  );
endinterface

// ===== sv/olr_out_if.sv =====
// Output channel of the line rasterizer: valid/ready plus the pixel fields.
// Depends on nothing; the top level takes the source modport.
interface olr_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [2:0]                   octant;
  logic                         last_pixel;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, octant, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, octant, last_pixel,
    output ready
  );
endinterface

// ===== sv/octant_line_rasterizer.sv =====
// Octant line rasterizer, top level. Needs olr_pkg, olr_in_if, olr_out_if,
// olr_setup and olr_unmap.
//
// Midpoint line walker for all eight octants. A load transfer (mode 0) takes
// both endpoints, classifies the octant, folds the line into octant 0 and
// returns the start pixel at once. Each step transfer (mode 1) returns the
// next pixel; the end point comes back with last_pixel set, after which the
// line is closed and further steps return pixel_valid 0 with all fields zero.
// A load always replaces whatever line was in progress. Every transfer gives
// exactly one result. Throughput is one transfer per clock while the sink
// keeps up: the walk state and the result register both update on the edge
// that takes the transfer, so a step may follow a load or a step directly.
// The single output register decouples the sides; input ready is low only
// while that register holds a result the sink has not yet taken. The longest
// path is the load setup (endpoint difference, magnitude compare, fold,
// subtract) feeding the end-point compare and the unmap mux.
module octant_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  olr_in_if.sink    line_in,
  olr_out_if.source pixel_out
);

  localparam int W = COORD_BITS + 1;  // octant-0 walk coordinates
  localparam int D = COORD_BITS + 4;  // decision term and increments

  localparam logic signed [W-1:0] WALK_ONE = W'(1);

  // ---------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------
  logic signed [W-1:0] walk_x, walk_y, walk_x_end;
  logic signed [W-1:0] walk_x_next, walk_y_next, walk_x_end_next;
  logic signed [D-1:0] decision, step_east, step_diagonal;
  logic signed [D-1:0] decision_next, step_east_next, step_diagonal_next;
  olr_pkg::octant_t    line_octant, line_octant_next;
  logic                line_active, line_active_next;

  // result register
  logic                         out_valid;
  logic                         pix_valid;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [2:0]                   pix_octant;
  logic                         pix_last;

  // setup outputs
  olr_pkg::octant_t    set_octant;
  logic signed [W-1:0] set_u, set_v, set_u_end;
  logic signed [D-1:0] set_decision, set_east, set_diagonal;

  logic                         xfer_in;
  logic                         is_load;
  logic                         emit;
  logic                         last;
  logic signed [COORD_BITS-1:0] map_x, map_y;

  // Take a new transfer whenever the result register is empty or draining.
  assign line_in.ready = !out_valid || pixel_out.ready;
  assign xfer_in       = line_in.valid && line_in.ready;
  assign is_load       = (line_in.mode == olr_pkg::MODE_LOAD);

  // A pixel comes out for every load, and for a step while a line is open.
  assign emit = xfer_in && (is_load || line_active);

  olr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .x_start       (line_in.x_start),
    .y_start       (line_in.y_start),
    .x_end         (line_in.x_end),
    .y_end         (line_in.y_end),
    .octant        (set_octant),
    .u_start       (set_u),
    .v_start       (set_v),
    .u_end         (set_u_end),
    .decision      (set_decision),
    .step_east     (set_east),
    .step_diagonal (set_diagonal)
  );

  // Next walk state: load replaces it, an open step advances it.
  always_comb begin
    walk_x_next        = walk_x;
    walk_y_next        = walk_y;
    walk_x_end_next    = walk_x_end;
    decision_next      = decision;
    step_east_next     = step_east;
    step_diagonal_next = step_diagonal;
    line_octant_next   = line_octant;
    if (xfer_in && is_load) begin
      walk_x_next        = set_u;
      walk_y_next        = set_v;
      walk_x_end_next    = set_u_end;
      decision_next      = set_decision;
      step_east_next     = set_east;
      step_diagonal_next = set_diagonal;
      line_octant_next   = set_octant;
    end else if (xfer_in && line_active) begin
      walk_x_next = walk_x + WALK_ONE;
      if (decision > 0) begin
        // midpoint below the line: diagonal move
        walk_y_next   = walk_y + WALK_ONE;
        decision_next = decision + step_diagonal;
      end else begin
        decision_next = decision + step_east;
      end
    end
  end

  // End point reached once the walk x meets the folded end x.
  assign last = (walk_x_next >= walk_x_end_next);

  always_comb begin
    line_active_next = line_active;
    if (emit) begin
      line_active_next = !last;
    end
  end

  olr_unmap #(
    .COORD_BITS(COORD_BITS)
  ) u_unmap (
    .octant (line_octant_next),
    .u      (walk_x_next),
    .v      (walk_y_next),
    .x      (map_x),
    .y      (map_y)
  );

  // Walk registers; all clear to zero with no line open.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x        <= '0;
      walk_y        <= '0;
      walk_x_end    <= '0;
      decision      <= '0;
      step_east     <= '0;
      step_diagonal <= '0;
      line_octant   <= olr_pkg::OCT_0;
      line_active   <= 1'b0;
    end else begin
      walk_x        <= walk_x_next;
      walk_y        <= walk_y_next;
      walk_x_end    <= walk_x_end_next;
      decision      <= decision_next;
      step_east     <= step_east_next;
      step_diagonal <= step_diagonal_next;
      line_octant   <= line_octant_next;
      line_active   <= line_active_next;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xfer_in) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; a step on a closed line reports all zeros.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      pix_valid  <= emit;
      pix_x      <= emit ? map_x : '0;
      pix_y      <= emit ? map_y : '0;
      pix_octant <= emit ? line_octant_next : 3'd0;
      pix_last   <= emit && last;
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_valid = pix_valid;
  assign pixel_out.pixel_x     = pix_x;
  assign pixel_out.pixel_y     = pix_y;
  assign pixel_out.octant      = pix_octant;
  assign pixel_out.last_pixel  = pix_last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Every transfer taken leaves a result in the output register.
  a_xfer_gives_result: assert property (
    @(posedge clk) disable iff (rst) xfer_in |=> out_valid
  ) else $error("accepted transfer produced no result");

  // A step on a closed line yields an empty result and keeps the line closed.
  a_idle_step_empty: assert property (
    @(posedge clk) disable iff (rst)
    xfer_in && !is_load && !line_active |=> !pix_valid && !line_active
  ) else $error("step with no open line produced a pixel");

  // An empty result carries zeroed fields.
  a_empty_is_zero: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !pix_valid |-> pix_x == '0 && pix_y == '0 && pix_octant == 3'd0 && !pix_last
  ) else $error("empty result carries nonzero fields");

  // Reporting the end point closes the line.
  a_last_closes: assert property (
    @(posedge clk) disable iff (rst)
    emit && last |=> !line_active && pix_last
  ) else $error("line still open after its end point");

endmodule

// ===== sv/olr_setup.sv =====
// Line setup: octant classification, fold of both endpoints into octant 0,
// initial decision term and increments. Pure combinational; uses olr_pkg.
module olr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output olr_pkg::octant_t             octant,
  output logic signed [COORD_BITS:0]   u_start,
  output logic signed [COORD_BITS:0]   v_start,
  output logic signed [COORD_BITS:0]   u_end,
  output logic signed [COORD_BITS+3:0] decision,
  output logic signed [COORD_BITS+3:0] step_east,
  output logic signed [COORD_BITS+3:0] step_diagonal
);

  localparam int W = COORD_BITS + 1;
  localparam int D = COORD_BITS + 4;

  logic signed [W-1:0] x0, y0, x1, y1, nx0, ny0, nx1, ny1;
  logic signed [W-1:0] dx, dy;
  logic        [W-1:0] adx, ady;
  logic signed [W-1:0] v_end;
  logic signed [W:0]   ddx, ddy;
  logic signed [D-1:0] ddx_w, ddy_w;

  assign x0 = {x_start[COORD_BITS-1], x_start};
  assign y0 = {y_start[COORD_BITS-1], y_start};
  assign x1 = {x_end[COORD_BITS-1], x_end};
  assign y1 = {y_end[COORD_BITS-1], y_end};
  assign nx0 = -x0;
  assign ny0 = -y0;
  assign nx1 = -x1;
  assign ny1 = -y1;

  assign dx  = x1 - x0;
  assign dy  = y1 - y0;
  assign adx = dx[W-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ady = dy[W-1] ? $unsigned(-dy) : $unsigned(dy);

  always_comb begin
    priority if (!dx[W-1] && !dy[W-1]) begin
      octant = (adx >= ady) ? olr_pkg::OCT_0 : olr_pkg::OCT_1;
    end else if (dx[W-1] && !dy[W-1]) begin
      octant = (ady >= adx) ? olr_pkg::OCT_2 : olr_pkg::OCT_3;
    end else if (dx[W-1] && dy[W-1]) begin
      octant = (adx >= ady) ? olr_pkg::OCT_4 : olr_pkg::OCT_5;
    end else begin
      octant = (ady >= adx) ? olr_pkg::OCT_6 : olr_pkg::OCT_7;
    end
  end

  // fold true coordinates into octant-0 space
  always_comb begin
    unique case (octant)
      olr_pkg::OCT_0: begin
        u_start = x0;  v_start = y0;  u_end = x1;  v_end = y1;
      end
      olr_pkg::OCT_1: begin
        u_start = y0;  v_start = x0;  u_end = y1;  v_end = x1;
      end
      olr_pkg::OCT_2: begin
        u_start = y0;  v_start = nx0; u_end = y1;  v_end = nx1;
      end
      olr_pkg::OCT_3: begin
        u_start = nx0; v_start = y0;  u_end = nx1; v_end = y1;
      end
      olr_pkg::OCT_4: begin
        u_start = nx0; v_start = ny0; u_end = nx1; v_end = ny1;
      end
      olr_pkg::OCT_5: begin
        u_start = ny0; v_start = nx0; u_end = ny1; v_end = nx1;
      end
      olr_pkg::OCT_6: begin
        u_start = ny0; v_start = x0;  u_end = ny1; v_end = x1;
      end
      default: begin
        u_start = x0;  v_start = ny0; u_end = x1;  v_end = ny1;
      end
    endcase
  end

  assign ddx   = {u_end[W-1], u_end} - {u_start[W-1], u_start};
  assign ddy   = {v_end[W-1], v_end} - {v_start[W-1], v_start};
  assign ddx_w = {{(D-W-1){ddx[W]}}, ddx};
  assign ddy_w = {{(D-W-1){ddy[W]}}, ddy};

  assign step_east     = ddy_w <<< 1;
  assign step_diagonal = (ddy_w - ddx_w) <<< 1;
  assign decision      = (ddy_w <<< 1) - ddx_w;

endmodule

// ===== sv/olr_unmap.sv =====
// Maps an octant-0 walk position back to true screen coordinates.
// Pure combinational; uses olr_pkg for the octant codes.
module olr_unmap #(
  parameter int COORD_BITS = 12
) (
  input  olr_pkg::octant_t             octant,
  input  logic signed [COORD_BITS:0]   u,
  input  logic signed [COORD_BITS:0]   v,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic signed [COORD_BITS:0] nu, nv, xw, yw;

  assign nu = -u;
  assign nv = -v;

  always_comb begin
    unique case (octant)
      olr_pkg::OCT_0: begin xw = u;  yw = v;  end
      olr_pkg::OCT_1: begin xw = v;  yw = u;  end
      olr_pkg::OCT_2: begin xw = nv; yw = u;  end
      olr_pkg::OCT_3: begin xw = nu; yw = v;  end
      olr_pkg::OCT_4: begin xw = nu; yw = nv; end
      olr_pkg::OCT_5: begin xw = nv; yw = nu; end
      olr_pkg::OCT_6: begin xw = v;  yw = nu; end
      default:        begin xw = u;  yw = nv; end
    endcase
  end

  // results wrap to the coordinate width
  assign x = xw[COORD_BITS-1:0];
  assign y = yw[COORD_BITS-1:0];

endmodule

// ===== test/olr_checker.sv =====
// Scoreboard for the octant line rasterizer: predicts each pixel from the input
// transfers and compares the output transfers. Needs olr_pkg, olr_in_if, olr_out_if.
module olr_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  olr_in_if    line_in,
  olr_out_if   pixel_out,
  output int   failures,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   walk_t;
  typedef logic signed [COORD_BITS+3:0] dec_t;

  typedef struct packed {
    logic             pixel_valid;
    coord_t           x;
    coord_t           y;
    olr_pkg::octant_t oct;
    logic             last;
  } pixel_t;

  pixel_t           pixel_q[$];
  walk_t            walk_x, walk_y, walk_x_end;
  dec_t             decision, step_east, step_diag;
  olr_pkg::octant_t line_oct;
  logic             line_active;
  int               errors = 0;

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic olr_pkg::octant_t classify(int dx, int dy);
    if (dx >= 0 && dy >= 0) return (dx >= dy) ? olr_pkg::OCT_0 : olr_pkg::OCT_1;
    if (dx < 0 && dy >= 0) return (dy >= magnitude(dx)) ? olr_pkg::OCT_2 : olr_pkg::OCT_3;
    if (dx < 0 && dy < 0)
      return (magnitude(dx) >= magnitude(dy)) ? olr_pkg::OCT_4 : olr_pkg::OCT_5;
    return (magnitude(dy) >= dx) ? olr_pkg::OCT_6 : olr_pkg::OCT_7;
  endfunction

  // true coordinates -> octant-0 frame
  function automatic void fold(olr_pkg::octant_t o, int x, int y, output int u, output int v);
    case (o)
      olr_pkg::OCT_0: begin u = x;  v = y;  end
      olr_pkg::OCT_1: begin u = y;  v = x;  end
      olr_pkg::OCT_2: begin u = y;  v = -x; end
      olr_pkg::OCT_3: begin u = -x; v = y;  end
      olr_pkg::OCT_4: begin u = -x; v = -y; end
      olr_pkg::OCT_5: begin u = -y; v = -x; end
      olr_pkg::OCT_6: begin u = -y; v = x;  end
      default:        begin u = x;  v = -y; end
    endcase
  endfunction

  // octant-0 frame -> true coordinates
  function automatic void unfold(olr_pkg::octant_t o, int u, int v, output int x, output int y);
    case (o)
      olr_pkg::OCT_0: begin x = u;  y = v;  end
      olr_pkg::OCT_1: begin x = v;  y = u;  end
      olr_pkg::OCT_2: begin x = -v; y = u;  end
      olr_pkg::OCT_3: begin x = -u; y = v;  end
      olr_pkg::OCT_4: begin x = -u; y = -v; end
      olr_pkg::OCT_5: begin x = -v; y = -u; end
      olr_pkg::OCT_6: begin x = v;  y = -u; end
      default:        begin x = u;  y = -v; end
    endcase
  endfunction

  task automatic start_line(int x0, int y0, int x1, int y1);
    int u0, v0, u1, v1, dx, dy;
    line_oct = classify(x1 - x0, y1 - y0);
    fold(line_oct, x0, y0, u0, v0);
    fold(line_oct, x1, y1, u1, v1);
    dx = u1 - u0;
    dy = v1 - v0;
    walk_x     = walk_t'(u0);
    walk_y     = walk_t'(v0);
    walk_x_end = walk_t'(u1);
    decision   = dec_t'(2 * dy - dx);
    step_east  = dec_t'(2 * dy);
    step_diag  = dec_t'(2 * (dy - dx));
  endtask

  task automatic current_pixel(output pixel_t p);
    int x, y;
    unfold(line_oct, int'(walk_x), int'(walk_y), x, y);
    p.pixel_valid = 1'b1;
    p.x           = coord_t'(x);
    p.y           = coord_t'(y);
    p.oct         = line_oct;
    p.last        = (walk_x >= walk_x_end);
    line_active   = !p.last;
  endtask

  always @(posedge clk) begin : monitor
    pixel_t want, got;
    logic   bad;
    if (rst) begin
      walk_x      = '0;
      walk_y      = '0;
      walk_x_end  = '0;
      decision    = '0;
      step_east   = '0;
      step_diag   = '0;
      line_oct    = olr_pkg::OCT_0;
      line_active = 1'b0;
      pixel_q.delete();
    end else begin
      if (line_in.valid && line_in.ready) begin
        if (line_in.mode == olr_pkg::MODE_LOAD) begin
          start_line(int'(line_in.x_start), int'(line_in.y_start),
                     int'(line_in.x_end), int'(line_in.y_end));
          current_pixel(want);
        end else if (!line_active) begin
          want = '0;
        end else begin
          if (decision > 0) begin
            walk_y   = walk_y + 1;
            decision = decision + step_diag;
          end else begin
            decision = decision + step_east;
          end
          walk_x = walk_x + 1;
          current_pixel(want);
        end
        pixel_q.push_back(want);
      end
      if (pixel_out.valid && pixel_out.ready) begin
        got.pixel_valid = pixel_out.pixel_valid;
        got.x           = pixel_out.pixel_x;
        got.y           = pixel_out.pixel_y;
        got.oct         = olr_pkg::octant_t'(pixel_out.octant);
        got.last        = pixel_out.last_pixel;
        if (pixel_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: pixel with nothing pending: v=%0b x=%0d y=%0d oct=%0d last=%0b",
                     $realtime, got.pixel_valid, got.x, got.y, got.oct, got.last);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          bad = (got.pixel_valid !== want.pixel_valid) || (got.x !== want.x) ||
                (got.y !== want.y) || (got.oct !== want.oct) || (got.last !== want.last);
          if (bad) begin
            if (errors < 10) begin
              $display("%0t: pixel mismatch: exp v=%0b x=%0d y=%0d oct=%0d last=%0b",
                       $realtime, want.pixel_valid, want.x, want.y, want.oct, want.last);
              $display("%0t:                 got v=%0b x=%0d y=%0d oct=%0d last=%0b",
                       $realtime, got.pixel_valid, got.x, got.y, got.oct, got.last);
            end
            errors++;
          end
        end
      end
    end
    failures <= errors;
    pending  <= pixel_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the line rasterizer test: clock, reset, load/step stimulus and output
// back-pressure. Needs olr_pkg, olr_in_if, olr_out_if, the block and olr_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS     = 12;
  localparam int RANDOM_ITEMS   = 750;
  localparam int MAX_WALK       = 40;    // steps walked on one line at most
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES   = 8;

  // deltas of one short line per octant, counter-clockwise from +x
  localparam int OCT_DX[8] = '{6, 2, -2, -6, -6, -2, 2, 6};
  localparam int OCT_DY[8] = '{2, 6, 6, 2, -2, -6, -6, -2};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   pending;
  int   items_sent = 0;
  int   send_pct = 0;   // chance of a gap before each input transfer

  olr_in_if  #(.COORD_BITS(COORD_BITS)) line_in ();
  olr_out_if #(.COORD_BITS(COORD_BITS)) pixel_out ();

  octant_line_rasterizer #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .pixel_out (pixel_out)
  );

  olr_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .pixel_out (pixel_out),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Gap lengths: one time in ten a long gap, otherwise a short one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Stall rate for a stretch of traffic; zero gives runs with no idling at all.
  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // One input transfer. Entered and left at a falling edge; valid stays high
  // across back-to-back transfers and only drops when a gap is taken.
  task automatic send(input olr_pkg::mode_t m, input coord_t xs, input coord_t ys,
                      input coord_t xe, input coord_t ye);
    int gap;
    gap = ($urandom_range(0, 99) < send_pct) ? gap_len() : 0;
    if (gap > 0) begin
      line_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    line_in.valid   = 1'b1;
    line_in.mode    = m;
    line_in.x_start = xs;
    line_in.y_start = ys;
    line_in.x_end   = xe;
    line_in.y_end   = ye;
    // ready seen right after the edge is its value at the edge
    @(posedge clk);
    while (!line_in.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (items_sent % 64 == 0) send_pct = pick_pct();
  endtask

  task automatic send_load(input coord_t xs, input coord_t ys, input coord_t xe,
                           input coord_t ye);
    send(olr_pkg::MODE_LOAD, xs, ys, xe, ye);
  endtask

  // Step with garbage endpoints: the block must ignore them.
  task automatic send_step();
    send(olr_pkg::MODE_STEP, coord_t'($urandom), coord_t'($urandom),
         coord_t'($urandom), coord_t'($urandom));
  endtask

  // Output back-pressure, decided at each falling edge.
  initial begin : sink_pacing
    int hold, pct, cyc;
    hold = 0;
    pct  = 0;
    cyc  = 0;
    pixel_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 150 == 0) pct = pick_pct();
      cyc++;
      if (hold > 0) begin
        pixel_out.ready = 1'b0;
        hold--;
      end else begin
        pixel_out.ready = 1'b1;
        if ($urandom_range(0, 99) < pct) hold = gap_len();
      end
    end
  end

  // Watchdog: any transfer (or reset) restarts the count.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (line_in.valid && line_in.ready) || (pixel_out.valid && pixel_out.ready))
        idle = 0;
      else
        idle++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    coord_t xs, ys, xe, ye;
    int     dx, dy, major, steps, r;
    line_in.valid   = 1'b0;
    line_in.mode    = olr_pkg::MODE_LOAD;
    line_in.x_start = '0;
    line_in.y_start = '0;
    line_in.x_end   = '0;
    line_in.y_end   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    // step before any line exists: invalid, all-zero result
    send_step();
    // zero-length line: single pixel flagged last, then nothing active
    send_load(coord_t'(5), coord_t'(-7), coord_t'(5), coord_t'(-7));
    send_step();
    // full-range diagonal, then a load that drops it mid-walk
    send_load(coord_t'(-2048), coord_t'(-2048), coord_t'(2047), coord_t'(2047));
    send_step();
    send_load(coord_t'(2047), coord_t'(2047), coord_t'(-2048), coord_t'(-2048));
    send_step();
    // one short line per octant, each abandoned after one step
    for (int o = 0; o < 8; o++) begin
      send_load(coord_t'(100), coord_t'(-100), coord_t'(100 + OCT_DX[o]),
                coord_t'(-100 + OCT_DY[o]));
      send_step();
    end
    // opposite corners
    send_load(coord_t'(-2048), coord_t'(2047), coord_t'(2047), coord_t'(-2048));
    send_step();

    // --- random part ---
    // Mostly complete lines: load then walk to the end. Some walks stop early
    // (dropped by the next load), some overrun the end into invalid steps,
    // and a few stray steps land between lines.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        send_step();
      end else begin
        xs = coord_t'($urandom);
        ys = coord_t'($urandom);
        r  = $urandom_range(0, 9);
        if (r == 0) begin
          xe = coord_t'($urandom);
          ye = coord_t'($urandom);
        end else if (r == 1) begin
          xe = coord_t'(int'(xs) + $urandom_range(0, 400) - 200);
          ye = coord_t'(int'(ys) + $urandom_range(0, 400) - 200);
        end else begin
          xe = coord_t'(int'(xs) + $urandom_range(0, 24) - 12);
          ye = coord_t'(int'(ys) + $urandom_range(0, 24) - 12);
        end
        // endpoints may wrap; the block sees the wrapped values, so does this
        dx    = int'(xe) - int'(xs);
        dy    = int'(ye) - int'(ys);
        major = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
        r     = $urandom_range(0, 9);
        if (r == 0)      steps = $urandom_range(0, major);
        else if (r == 1) steps = major + $urandom_range(1, 3);
        else             steps = major;
        if (steps > MAX_WALK) steps = MAX_WALK;
        send_load(xs, ys, xe, ye);
        repeat (steps) send_step();
      end
    end
    line_in.valid = 1'b0;

    // drain: every predicted pixel must come back, then a quiet tail
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/olr_pkg.sv
sv/olr_in_if.sv
sv/olr_out_if.sv
sv/olr_setup.sv
sv/olr_unmap.sv
sv/octant_line_rasterizer.sv
test/olr_checker.sv
test/testbench.sv
